[rtl/core/cbt_pkg.sv]
package cbt_pkg;

  // default sizes
  localparam int NodeCountDef = 1024;
  localparam int KeyBitsDef   = 32;
  localparam int ValueBitsDef = 16;

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  // result codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_ZERO      = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUP       = 3'd4
  } status_t;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_WALK,
    S_CHECK,
    S_FIND_D,
    S_SCAN_START,
    S_SCAN,
    S_WALK2,
    S_W_LEAF,
    S_W_SIB,
    S_W_LINK,
    S_DEL_READ,
    S_DEL_WRITE,
    S_RESP
  } state_t;

  // slot write source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_NEW_LEAF,
    WR_SIB,
    WR_LINK,
    WR_PARENT
  } wsel_t;

  typedef struct packed {
    logic    load;
    logic    walk_start;
    logic    walk_step;
    logic    d_start;
    logic    d_step;
    logic    scan_start;
    logic    scan_step;
    logic    clr_step;
    logic    root_leaf;
    logic    root_clear;
    logic    sib_read;
    logic    mark_used;
    logic    free_node;
    wsel_t   wsel;
    logic    code_set;
    status_t code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_lookup;
    logic is_delete;
    logic value_zero;
    logic root_used;
    logic cur_leaf;
    logic pos_root;
    logic level_max;
    logic key_eq;
    logic crit_gt_d;
    logic d_done;
    logic slot_free;
    logic scan_last;
    logic clear_done;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/crit_bit_trie_index_unit.sv]
// Crit-bit trie map from KEY_BITS-bit keys to nonzero values, one request at a time.
// A request is {operation: insert, lookup, delete; key; value} and gives one response
// {status, found_value}. The walk reads one child slot per trie level from a slot memory
// with one read and one write port; a delete that lifts a sibling then reads the sibling
// slot and writes it into the parent slot. An insert walks twice, searches the lowest
// differing key bit one bit per cycle (up to KEY_BITS) and scans the node pool flags one
// entry per cycle for the lowest free node (up to NODE_COUNT), then writes the new leaf,
// the sibling slot and the link. After reset a clearing pass empties the pool flags; no
// request is taken during it. A response waits in an output register until taken; the
// next request is taken once it is there.
module crit_bit_trie_index_unit #(
  parameter int NODE_COUNT = cbt_pkg::NodeCountDef,
  parameter int KEY_BITS   = cbt_pkg::KeyBitsDef,
  parameter int VALUE_BITS = cbt_pkg::ValueBitsDef,
  localparam int IN_W  = ((2 + KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 + VALUE_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // operation, key, value
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status, found_value
);

  cbt_pkg::cmd_t cmd;
  cbt_pkg::sts_t sts;

  // sequencer
  cbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // trie storage and walk
  cbt_datapath #(
    .NODE_COUNT (NODE_COUNT),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[rtl/core/cbt_ctrl.sv]
module cbt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  cbt_pkg::sts_t sts,
  output cbt_pkg::cmd_t cmd
);

  cbt_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbt_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == cbt_pkg::S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cbt_pkg::S_CLEAR: begin
        if (sts.clear_done) state_next = cbt_pkg::S_IDLE;
      end
      cbt_pkg::S_IDLE: begin
        if (s_tvalid) state_next = cbt_pkg::S_START;
      end
      cbt_pkg::S_START: begin
        if (sts.is_insert) begin
          if (sts.value_zero || !sts.root_used) state_next = cbt_pkg::S_RESP;
          else state_next = cbt_pkg::S_WALK;
        end else if ((sts.is_lookup || sts.is_delete) && sts.root_used) begin
          state_next = cbt_pkg::S_WALK;
        end else begin
          state_next = cbt_pkg::S_RESP;
        end
      end
      cbt_pkg::S_WALK: begin
        if (sts.cur_leaf) state_next = cbt_pkg::S_CHECK;
        else if (sts.level_max) state_next = cbt_pkg::S_RESP;
      end
      cbt_pkg::S_CHECK: begin
        if (sts.key_eq && sts.is_delete && !sts.pos_root) state_next = cbt_pkg::S_DEL_READ;
        else if (!sts.key_eq && sts.is_insert) state_next = cbt_pkg::S_FIND_D;
        else state_next = cbt_pkg::S_RESP;
      end
      cbt_pkg::S_FIND_D: begin
        if (sts.d_done) state_next = cbt_pkg::S_SCAN_START;
      end
      cbt_pkg::S_SCAN_START: state_next = cbt_pkg::S_SCAN;
      cbt_pkg::S_SCAN: begin
        if (sts.slot_free) state_next = cbt_pkg::S_WALK2;
        else if (sts.scan_last) state_next = cbt_pkg::S_RESP;
      end
      cbt_pkg::S_WALK2: begin
        if (sts.cur_leaf || sts.crit_gt_d || sts.level_max) state_next = cbt_pkg::S_W_LEAF;
      end
      cbt_pkg::S_W_LEAF:    state_next = cbt_pkg::S_W_SIB;
      cbt_pkg::S_W_SIB:     state_next = cbt_pkg::S_W_LINK;
      cbt_pkg::S_W_LINK:    state_next = cbt_pkg::S_RESP;
      cbt_pkg::S_DEL_READ:  state_next = cbt_pkg::S_DEL_WRITE;
      cbt_pkg::S_DEL_WRITE: state_next = cbt_pkg::S_RESP;
      cbt_pkg::S_RESP: begin
        if (sts.out_free) state_next = cbt_pkg::S_IDLE;
      end
      default: state_next = cbt_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.wsel = cbt_pkg::WR_NONE;
    cmd.code = cbt_pkg::ST_OK;
    unique case (state)
      cbt_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      cbt_pkg::S_IDLE:  cmd.load = s_tvalid;
      cbt_pkg::S_START: begin
        cmd.code_set = 1'b1;
        if (sts.is_insert) begin
          if (sts.value_zero) begin
            cmd.code = cbt_pkg::ST_ZERO;
          end else if (!sts.root_used) begin
            cmd.root_leaf = 1'b1;
          end else begin
            cmd.walk_start = 1'b1;
          end
        end else if ((sts.is_lookup || sts.is_delete) && sts.root_used) begin
          cmd.walk_start = 1'b1;
        end else begin
          cmd.code = cbt_pkg::ST_NOT_FOUND;
        end
      end
      cbt_pkg::S_WALK: begin
        if (!sts.cur_leaf) begin
          if (sts.level_max) begin
            cmd.code_set = 1'b1;
            cmd.code     = cbt_pkg::ST_NOT_FOUND;
          end else begin
            cmd.walk_step = 1'b1;
          end
        end
      end
      cbt_pkg::S_CHECK: begin
        cmd.code_set = 1'b1;
        if (sts.key_eq) begin
          if (sts.is_insert) cmd.code = cbt_pkg::ST_DUP;
          else if (sts.is_delete && sts.pos_root) cmd.root_clear = 1'b1;
        end else if (sts.is_insert) begin
          cmd.d_start = 1'b1;
        end else begin
          cmd.code = cbt_pkg::ST_NOT_FOUND;
        end
      end
      cbt_pkg::S_FIND_D: cmd.d_step = !sts.d_done;
      cbt_pkg::S_SCAN_START: cmd.scan_start = 1'b1;
      cbt_pkg::S_SCAN: begin
        if (sts.slot_free) begin
          cmd.walk_start = 1'b1;
        end else if (sts.scan_last) begin
          cmd.code_set = 1'b1;
          cmd.code     = cbt_pkg::ST_FULL;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      cbt_pkg::S_WALK2: begin
        cmd.walk_step = !(sts.cur_leaf || sts.crit_gt_d || sts.level_max);
      end
      cbt_pkg::S_W_LEAF: begin
        cmd.wsel      = cbt_pkg::WR_NEW_LEAF;
        cmd.mark_used = 1'b1;
      end
      cbt_pkg::S_W_SIB: cmd.wsel = cbt_pkg::WR_SIB;
      cbt_pkg::S_W_LINK: begin
        cmd.wsel     = cbt_pkg::WR_LINK;
        cmd.code_set = 1'b1;
      end
      cbt_pkg::S_DEL_READ: cmd.sib_read = 1'b1;
      cbt_pkg::S_DEL_WRITE: begin
        cmd.wsel      = cbt_pkg::WR_PARENT;
        cmd.free_node = 1'b1;
        cmd.code_set  = 1'b1;
      end
      cbt_pkg::S_RESP: cmd.out_load = sts.out_free;
      default: cmd.load = 1'b0;
    endcase
  end

  // a result is only loaded into a free output register
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> sts.out_free)
    else $error("result loaded while output busy");

  // a walk never steps past a leaf
  assert property (@(posedge clk) disable iff (rst) cmd.walk_step |-> !sts.cur_leaf)
    else $error("walk stepped from a leaf");

  // an exhausted free scan ends in a response
  assert property (@(posedge clk) disable iff (rst)
    (state == cbt_pkg::S_SCAN && !sts.slot_free && sts.scan_last)
      |=> state == cbt_pkg::S_RESP)
    else $error("full pool not reported");

endmodule

[rtl/core/cbt_datapath.sv]
module cbt_datapath #(
  parameter int NODE_COUNT = cbt_pkg::NodeCountDef,
  parameter int KEY_BITS   = cbt_pkg::KeyBitsDef,
  parameter int VALUE_BITS = cbt_pkg::ValueBitsDef,
  localparam int IN_W  = ((2 + KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 + VALUE_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cbt_pkg::cmd_t      cmd,
  output cbt_pkg::sts_t      sts,
  input  logic [IN_W-1:0]    s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int SLOT_W = NODE_W + 1;
  localparam int CRIT_W = $clog2(KEY_BITS);
  localparam int LINK_W = (VALUE_BITS > NODE_W) ? VALUE_BITS : NODE_W;
  localparam int WORD_W = 1 + LINK_W + KEY_BITS;
  localparam int LVL_W  = $clog2(KEY_BITS + 1);
  localparam int SLOTS  = 2 * NODE_COUNT;

  // request registers
  logic [1:0]            op;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  // root link
  logic                root_used;
  logic                root_leaf;
  logic [LINK_W-1:0]   root_link;
  logic [KEY_BITS-1:0] root_key;

  // child slots: {leaf, link, key}; an inner slot keeps its crit bit in the key field
  logic [WORD_W-1:0] slot_mem [SLOTS];
  logic [WORD_W-1:0] slot_rd;
  logic              slot_wen;
  logic [SLOT_W-1:0] slot_waddr;
  logic [WORD_W-1:0] slot_wdata;
  logic              slot_ren;
  logic [SLOT_W-1:0] slot_raddr;

  // node pool flags
  logic              used_mem [NODE_COUNT];
  logic              used_rd;
  logic              used_wen;
  logic [NODE_W-1:0] used_waddr;
  logic              used_wdata;
  logic [NODE_W-1:0] used_raddr;

  // walk state
  logic              cur_from_root;
  logic [SLOT_W-1:0] pos;
  logic              pos_root;
  logic [SLOT_W-1:0] parent;
  logic              parent_root;
  logic [LVL_W-1:0]  level;
  logic [CRIT_W-1:0] d;
  logic [NODE_W-1:0] scan_idx;
  logic [NODE_W-1:0] clr_idx;

  // result
  cbt_pkg::status_t      code;
  cbt_pkg::status_t      out_status;
  logic [VALUE_BITS-1:0] out_found;

  // current slot view
  logic                cur_leaf;
  logic [LINK_W-1:0]   cur_link;
  logic [KEY_BITS-1:0] cur_key;
  logic [WORD_W-1:0]   cur_word;
  logic [NODE_W-1:0]   cur_node;
  logic [CRIT_W-1:0]   cur_crit;
  logic [SLOT_W-1:0]   next_pos;
  logic                kb;

  assign cur_word = cur_from_root ? {root_leaf, root_link, root_key} : slot_rd;
  assign cur_leaf = cur_word[WORD_W-1];
  assign cur_link = cur_word[KEY_BITS +: LINK_W];
  assign cur_key  = cur_word[KEY_BITS-1:0];
  assign cur_crit = cur_key[CRIT_W-1:0];
  assign cur_node = ({1'b0, cur_link} < (LINK_W + 1)'(NODE_COUNT)) ?
                    cur_link[NODE_W-1:0] : '0;
  assign next_pos = {cur_node, key_q[cur_crit]};
  assign kb       = key_q[d];

  // status to controller
  always_comb begin
    sts.is_insert  = (op == cbt_pkg::OP_INSERT);
    sts.is_lookup  = (op == cbt_pkg::OP_LOOKUP);
    sts.is_delete  = (op == cbt_pkg::OP_DELETE);
    sts.value_zero = (val_q == '0);
    sts.root_used  = root_used;
    sts.cur_leaf   = cur_leaf;
    sts.pos_root   = pos_root;
    sts.level_max  = (level == LVL_W'(KEY_BITS));
    sts.key_eq     = (cur_key == key_q);
    sts.crit_gt_d  = (cur_crit > d);
    sts.d_done     = (cur_key[d] ^ key_q[d]) || (d == CRIT_W'(KEY_BITS - 1));
    sts.slot_free  = !used_rd;
    sts.scan_last  = (scan_idx == NODE_W'(NODE_COUNT - 1));
    sts.clear_done = (clr_idx == NODE_W'(NODE_COUNT - 1));
    sts.out_free   = !m_tvalid || m_tready;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= s_tdata[1:0];
      key_q <= s_tdata[2 +: KEY_BITS];
      val_q <= s_tdata[2 + KEY_BITS +: VALUE_BITS];
    end
  end

  // slot write select
  always_comb begin
    slot_wen   = 1'b0;
    slot_waddr = pos;
    slot_wdata = cur_word;
    case (cmd.wsel)
      cbt_pkg::WR_NEW_LEAF: begin
        slot_wen   = 1'b1;
        slot_waddr = {scan_idx, kb};
        slot_wdata = {1'b1, LINK_W'(val_q), key_q};
      end
      cbt_pkg::WR_SIB: begin
        slot_wen   = 1'b1;
        slot_waddr = {scan_idx, ~kb};
        slot_wdata = cur_word;
      end
      cbt_pkg::WR_LINK: begin
        slot_wen   = !pos_root;
        slot_waddr = pos;
        slot_wdata = {1'b0, LINK_W'(scan_idx), KEY_BITS'(d)};
      end
      cbt_pkg::WR_PARENT: begin
        slot_wen   = !parent_root;
        slot_waddr = parent;
        slot_wdata = cur_word;
      end
      default: slot_wen = 1'b0;
    endcase
  end

  assign slot_ren   = cmd.walk_step || cmd.sib_read;
  assign slot_raddr = cmd.walk_step ? next_pos : {pos[SLOT_W-1:1], ~pos[0]};

  // slot memory
  always_ff @(posedge clk) begin
    if (slot_wen) slot_mem[slot_waddr] <= slot_wdata;
  end

  always_ff @(posedge clk) begin
    if (slot_ren) slot_rd <= slot_mem[slot_raddr];
  end

  // root link
  always_ff @(posedge clk) begin
    if (rst) begin
      root_used <= 1'b0;
      root_leaf <= 1'b0;
      root_link <= '0;
      root_key  <= '0;
    end else if (cmd.root_leaf) begin
      root_used <= 1'b1;
      root_leaf <= 1'b1;
      root_link <= LINK_W'(val_q);
      root_key  <= key_q;
    end else if (cmd.root_clear) begin
      root_used <= 1'b0;
      root_leaf <= 1'b0;
      root_link <= '0;
      root_key  <= '0;
    end else if (cmd.wsel == cbt_pkg::WR_LINK && pos_root) begin
      root_used <= 1'b1;
      root_leaf <= 1'b0;
      root_link <= LINK_W'(scan_idx);
      root_key  <= KEY_BITS'(d);
    end else if (cmd.wsel == cbt_pkg::WR_PARENT && parent_root) begin
      root_used <= 1'b1;
      root_leaf <= cur_leaf;
      root_link <= cur_link;
      root_key  <= cur_key;
    end
  end

  // pool flag write select
  always_comb begin
    used_wen   = cmd.clr_step || cmd.mark_used || cmd.free_node;
    used_waddr = clr_idx;
    used_wdata = 1'b0;
    if (cmd.mark_used) begin
      used_waddr = scan_idx;
      used_wdata = 1'b1;
    end else if (cmd.free_node) begin
      used_waddr = pos[SLOT_W-1:1];
    end
  end

  assign used_raddr = cmd.scan_start ? '0 : scan_idx + 1'b1;

  // pool flag memory
  always_ff @(posedge clk) begin
    if (used_wen) used_mem[used_waddr] <= used_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start || cmd.scan_step) used_rd <= used_mem[used_raddr];
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_from_root <= 1'b1;
      pos_root      <= 1'b1;
      parent_root   <= 1'b1;
      level         <= '0;
    end else if (cmd.walk_start) begin
      cur_from_root <= 1'b1;
      pos_root      <= 1'b1;
      parent_root   <= 1'b1;
      level         <= '0;
    end else if (cmd.walk_step) begin
      cur_from_root <= 1'b0;
      pos_root      <= 1'b0;
      parent_root   <= pos_root;
      level         <= level + 1'b1;
    end else if (cmd.sib_read) begin
      cur_from_root <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step) begin
      pos    <= next_pos;
      parent <= pos;
    end
  end

  // crit bit search and free node scan
  always_ff @(posedge clk) begin
    if (cmd.d_start) d <= '0;
    else if (cmd.d_step) d <= d + 1'b1;
    if (cmd.scan_start) scan_idx <= '0;
    else if (cmd.scan_step) scan_idx <= scan_idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.code_set) code <= cmd.code;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= code;
      out_found  <= (code == cbt_pkg::ST_OK && op == cbt_pkg::OP_LOOKUP) ?
                    cur_link[VALUE_BITS-1:0] : '0;
    end
  end

  assign m_tdata = OUT_W'({out_found, out_status});

endmodule
